/* rtl/core/itr_pkg.sv */
// Shared constants and the digit coding function for the radix text converter.
`timescale 1ns / 1ps
`default_nettype none

package itr_pkg;

  // Default sizing of the converter.
  localparam int unsigned VALUE_BITS_DEF    = 32;
  localparam int unsigned MAX_PAD_WIDTH_DEF = 16;

  // Field widths.
  localparam int unsigned DIGIT_W = 6;   // radix and one digit value
  localparam int unsigned CHAR_W  = 8;   // one ASCII character
  localparam int unsigned WIDTH_W = 5;   // requested minimum width

  // Quotient bits retired by the divider per clock.
  localparam int unsigned DIV_STEP_BITS = 4;

  // Radix limits.
  localparam logic [DIGIT_W-1:0] RADIX_MIN = DIGIT_W'(2);
  localparam logic [DIGIT_W-1:0] RADIX_MAX = DIGIT_W'(36);

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] LETTER_GAP = 8'd7;
  localparam logic [CHAR_W-1:0] DEC_DIGITS = 8'd10;

  // Map a digit value 0..35 onto '0'-'9', 'A'-'Z'.
  function automatic logic [CHAR_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'(d);
    if (c >= DEC_DIGITS) begin
      c = c + LETTER_GAP;
    end
    return c + CHAR_ZERO;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/integer_to_text_radix.sv */
// Top level of the integer to radix text converter: sequencer, digit buffer, output register.
//
// Usage: present value_i, radix_i (2..36, saturated outside), signed_mode_i, width_i
// (minimum text length, saturated to MAX_PAD_WIDTH) and zero_pad_i with in_valid_i; the
// item is taken at an edge where in_valid_i is high and in_stall_o is low. The text comes
// out one ASCII character per item on character_o, most significant first, last_o high on
// the final one, handshaken by out_valid_o / out_stall_i. Padding stands before a sign.
// Timing: one item at a time. For each digit the shared divider retires four quotient
// bits a clock, then the digit is written into the buffer. The sign and the pad
// characters follow; each output character is read from the buffer, then loaded into
// the output register. in_stall_o is high from acceptance until the last character is
// loaded; the last character may still wait in the output register while the next
// item is accepted.
// A stall on the output holds the character and freezes the read-out.
// Reset clears the sequencer and the output valid; the buffer needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_text_radix #(
  parameter int unsigned VALUE_BITS    = itr_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_PAD_WIDTH = itr_pkg::MAX_PAD_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input item channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [VALUE_BITS-1:0]        value_i,
  input  wire logic [itr_pkg::DIGIT_W-1:0]  radix_i,
  input  wire logic                         signed_mode_i,
  input  wire logic [itr_pkg::WIDTH_W-1:0]  width_i,
  input  wire logic                         zero_pad_i,
  // output item channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [itr_pkg::CHAR_W-1:0]   character_o,
  output logic                              last_o
);

  import itr_pkg::*;

  // The buffer holds every digit plus a sign, or the widest padded text.
  localparam int unsigned BUF_SLOTS = (VALUE_BITS + 1 > MAX_PAD_WIDTH) ?
                                      VALUE_BITS + 1 : MAX_PAD_WIDTH;
  localparam int unsigned ADDR_W    = $clog2(BUF_SLOTS);
  localparam int unsigned CNT_W     = $clog2(BUF_SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SIGN = 6'b000100,
    ST_PAD  = 6'b001000,
    ST_READ = 6'b010000,
    ST_LOAD = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   wid_q, wid_d;
  logic               neg_q, neg_d;
  logic [CHAR_W-1:0]  pad_q, pad_d;
  logic [DIGIT_W-1:0] radix_q, radix_d;

  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_last_q;
  logic               out_load;
  logic               out_free;

  logic               in_accept;
  logic [DIGIT_W-1:0] rdx_sat;
  logic [CNT_W-1:0]   wid_sat;
  logic               in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic [CNT_W-1:0]   cnt_dec;

  // divider hookup
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [DIGIT_W-1:0]    div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  // buffer hookup
  logic              ram_we;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [CHAR_W-1:0] ram_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_dec    = cnt_q - CNT_W'(1);

  // Saturate the radix and width, fold a negative value into its magnitude.
  always_comb begin
    if (radix_i < RADIX_MIN) begin
      rdx_sat = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      rdx_sat = RADIX_MAX;
    end else begin
      rdx_sat = radix_i;
    end
    if (32'(width_i) > 32'(MAX_PAD_WIDTH)) begin
      wid_sat = CNT_W'(MAX_PAD_WIDTH);
    end else begin
      wid_sat = CNT_W'(width_i);
    end
    in_neg = signed_mode_i && value_i[VALUE_BITS-1];
    in_mag = in_neg ? (~value_i + VALUE_BITS'(1)) : value_i;
  end

  // Sequencer: digits least significant first into the buffer, then sign and
  // padding, then read back from the top slot down.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    wid_d        = wid_q;
    neg_d        = neg_q;
    pad_d        = pad_q;
    radix_d      = radix_q;
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_divisor  = radix_q;
    ram_we       = 1'b0;
    ram_wdata    = pad_q;
    ram_re       = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        div_dividend = in_mag;
        div_divisor  = rdx_sat;
        if (in_accept) begin
          radix_d   = rdx_sat;
          wid_d     = wid_sat;
          neg_d     = in_neg;
          pad_d     = zero_pad_i ? CHAR_ZERO : CHAR_SPACE;
          cnt_d     = '0;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        ram_wdata = digit_code(div_rem);
        if (div_done) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          if (div_quot != '0) begin
            div_start = 1'b1;
          end else if (neg_q) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_SIGN: begin
        ram_we    = 1'b1;
        ram_wdata = CHAR_MINUS;
        cnt_d     = cnt_q + CNT_W'(1);
        state_d   = ST_PAD;
      end
      ST_PAD: begin
        if (cnt_q < wid_q) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        cnt_d   = cnt_dec;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          out_load = 1'b1;
          state_d  = (cnt_q == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wid_q   <= wid_d;
    neg_q   <= neg_d;
    pad_q   <= pad_d;
    radix_q <= radix_d;
    if (out_load) begin
      out_char_q <= ram_rdata;
      out_last_q <= (cnt_q == '0);
    end
  end

  itr_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  itr_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUF_SLOTS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_dec[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;

  // The divider finishes only while the sequencer collects digits.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the digit phase");

  // Buffer writes stay inside the buffer.
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cnt_q < CNT_W'(BUF_SLOTS)))
    else $error("digit buffer write out of range");

  // An accepted item blocks the input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // Loading the bottom slot flags the last character and frees the block.
  a_last_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (cnt_q == '0)) |=> (out_valid_o && last_o && !in_stall_o))
    else $error("final character not flagged");

endmodule

`default_nettype wire

/* rtl/core/itr_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module itr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 33
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/itr_div.sv */
// Iterative radix divider: retires a few quotient bits per clock, narrow remainder.
`timescale 1ns / 1ps
`default_nettype none

module itr_div #(
  parameter int unsigned VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [VALUE_BITS-1:0]        dividend_i,
  input  wire logic [itr_pkg::DIGIT_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic      [VALUE_BITS-1:0]        quotient_o,
  output logic      [itr_pkg::DIGIT_W-1:0]  remainder_o
);

  import itr_pkg::*;

  localparam int unsigned STEPS = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned DIV_W = STEPS * DIV_STEP_BITS;
  localparam int unsigned SC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy_q;
  logic              done_q;
  logic [SC_W-1:0]   step_q;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [DIGIT_W-1:0] dvs_q;
  logic [DIV_W-1:0]  sh_q, sh_d;

  // Restoring division, DIV_STEP_BITS bits per clock.
  always_comb begin
    logic [DIGIT_W:0] r;
    logic [DIV_W-1:0] s;
    r = {1'b0, rem_q};
    s = sh_q;
    for (int i = 0; i < int'(DIV_STEP_BITS); i++) begin
      r = {r[DIGIT_W-1:0], s[DIV_W-1]};
      s = {s[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r    = r - {1'b0, dvs_q};
        s[0] = 1'b1;
      end
    end
    rem_d = r[DIGIT_W-1:0];
    sh_d  = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= SC_W'(STEPS - 1);
    end else if (busy_q) begin
      step_q <= step_q - SC_W'(1);
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= DIV_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = sh_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* test/integer_to_text_radix_checker.sv */
// Checker for the radix text converter: predicts the text of each item and compares it.
`timescale 1ns / 1ps

module integer_to_text_radix_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [31:0]                   value_i,
  input  logic [itr_pkg::DIGIT_W-1:0]   radix_i,
  input  logic                          signed_mode_i,
  input  logic [itr_pkg::WIDTH_W-1:0]   width_i,
  input  logic                          zero_pad_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [itr_pkg::CHAR_W-1:0]    character_i,
  input  logic                          last_i,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o,
  output int unsigned                   chars_checked_o
);
  import itr_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  text_char_t  text_due[$];
  int unsigned fails = 0;
  int unsigned checked = 0;

  // Build the text of one item, most significant character first, and queue it.
  function automatic void render_text(input logic [31:0] val, input logic [DIGIT_W-1:0] rdx,
                                      input logic sgn, input logic [WIDTH_W-1:0] wid,
                                      input logic zp);
    logic [CHAR_W-1:0]  text[$];
    logic [31:0]        mag;
    logic [DIGIT_W-1:0] base;
    logic [CHAR_W-1:0]  d;
    logic [CHAR_W-1:0]  pad;
    int unsigned        min_len;
    int                 n;
    base    = (rdx < RADIX_MIN) ? RADIX_MIN : ((rdx > RADIX_MAX) ? RADIX_MAX : rdx);
    min_len = (wid > WIDTH_W'(MAX_PAD_WIDTH_DEF)) ? MAX_PAD_WIDTH_DEF : wid;
    pad     = zp ? CHAR_ZERO : CHAR_SPACE;
    mag     = val;
    // negation of the most negative value wraps onto itself, read back as unsigned
    if (sgn && val[31]) begin
      mag = -val;
    end
    do begin
      d = CHAR_W'(mag % 32'(base));
      text.push_front((d >= DEC_DIGITS) ? d + LETTER_GAP + CHAR_ZERO : d + CHAR_ZERO);
      mag = mag / 32'(base);
    end while (mag != 0);
    if (sgn && val[31]) begin
      text.push_front(CHAR_MINUS);
    end
    // padding stands before the sign
    while (text.size() < min_len) begin
      text.push_front(pad);
    end
    n = text.size();
    foreach (text[i]) begin
      text_due.push_back('{character: text[i], last: (i == n - 1)});
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      // check the output first, so a character taken in the same cycle as a new item
      // is matched against what was already waiting
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (text_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("checker: unexpected character %h last %b", character_i, last_i);
          end
        end else begin
          want = text_due.pop_front();
          if (character_i !== want.character || last_i !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("checker: character %0d expected %h last %b, got %h last %b",
                       checked, want.character, want.last, character_i, last_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        render_text(value_i, radix_i, signed_mode_i, width_i, zero_pad_i);
      end
    end
    pending_o       <= text_due.size();
    fail_count_o    <= fails;
    chars_checked_o <= checked;
  end

endmodule

/* test/integer_to_text_radix_test.sv */
// Testbench top for the radix text converter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module integer_to_text_radix_test;
  import itr_pkg::*;

  localparam int unsigned DIRECTED_ITEMS = 23;
  localparam int unsigned RANDOM_ITEMS   = 287;
  // receiver hold-off long enough to back the block up onto its input
  localparam int unsigned LONG_HOLD      = 400;
  // worst quiet stretch: long hold plus a 33 character binary conversion plus a gap
  localparam int unsigned IDLE_LIMIT     = 4000;
  // settle time after the last expected character, covers one full conversion
  localparam int unsigned SETTLE_CYCLES  = 400;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [31:0]        value       = '0;
  logic [DIGIT_W-1:0] radix       = RADIX_MIN;
  logic               signed_mode = 1'b0;
  logic [WIDTH_W-1:0] width       = '0;
  logic               zero_pad    = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b1;
  logic [CHAR_W-1:0]  character;
  logic               last;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned chars_checked;
  int unsigned items_sent    = 0;
  int unsigned results_taken = 0;
  int unsigned idle_cycles   = 0;
  bit          send_burst    = 1'b0;
  bit          take_burst    = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  integer_to_text_radix i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .value_i       (value),
    .radix_i       (radix),
    .signed_mode_i (signed_mode),
    .width_i       (width),
    .zero_pad_i    (zero_pad),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .character_o   (character),
    .last_o        (last)
  );

  integer_to_text_radix_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .value_i         (value),
    .radix_i         (radix),
    .signed_mode_i   (signed_mode),
    .width_i         (width),
    .zero_pad_i      (zero_pad),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .character_i     (character),
    .last_i          (last),
    .pending_o       (pending),
    .fail_count_o    (fail_count),
    .chars_checked_o (chars_checked)
  );

  // Offer one item after a random gap, then hold it until the block takes it.
  // Called at a clock edge; returns at the edge where the item was accepted.
  task automatic send_item(input logic [31:0] val, input logic [DIGIT_W-1:0] rdx,
                           input logic sgn, input logic [WIDTH_W-1:0] wid, input logic zp);
    int unsigned gap;
    // flip between bursts with no gaps and gapped traffic now and then
    if ($urandom_range(0, 19) == 0) begin
      send_burst = !send_burst;
    end
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    value       <= val;
    radix       <= rdx;
    signed_mode <= sgn;
    width       <= wid;
    zero_pad    <= zp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold off until every queued character has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stall before each character, bursts without stalls, and two
  // long hold-offs so the block fills up while the sender keeps offering items.
  initial begin : receiver
    int unsigned hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken == 50 || results_taken == 1500) begin
        hold = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          take_burst = !take_burst;
        end
        hold = take_burst ? 0 : $urandom_range(0, 16);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d characters pending",
               IDLE_LIMIT, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0]        v;
    logic [DIGIT_W-1:0] r;
    logic [WIDTH_W-1:0] w;
    int unsigned        pick;

    // hold reset low, then release it at an edge
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero: a single digit, and padded all the way to the maximum width
    send_item(32'h0000_0000, 6'd10, 1'b0, 5'd0, 1'b0);
    send_item(32'h0000_0000, 6'd10, 1'b0, 5'd16, 1'b1);
    // all ones in binary: 32 digits; most negative in binary: 32 digits and a sign
    send_item(32'hFFFF_FFFF, 6'd2, 1'b0, 5'd0, 1'b0);
    send_item(32'h8000_0000, 6'd2, 1'b1, 5'd0, 1'b1);
    send_item(32'h8000_0000, 6'd10, 1'b1, 5'd16, 1'b1);
    send_item(32'hFFFF_FFFF, 6'd10, 1'b1, 5'd0, 1'b0);
    // padding lands in front of the sign, with zeros and with spaces
    send_item(32'hFFFF_FFFB, 6'd10, 1'b1, 5'd4, 1'b1);
    send_item(32'hFFFF_FFFB, 6'd10, 1'b1, 5'd4, 1'b0);
    // letters: top radix, last letter, first letter
    send_item(32'hFFFF_FFFF, 6'd36, 1'b0, 5'd0, 1'b0);
    send_item(32'd35, 6'd36, 1'b0, 5'd0, 1'b0);
    send_item(32'd10, 6'd11, 1'b0, 5'd0, 1'b0);
    // radix below two and above thirty-six saturate
    send_item(32'd5, 6'd0, 1'b0, 5'd0, 1'b0);
    send_item(32'd5, 6'd1, 1'b0, 5'd8, 1'b1);
    send_item(32'd1296, 6'd37, 1'b0, 5'd0, 1'b0);
    send_item(32'hDEAD_BEEF, 6'd63, 1'b1, 5'd0, 1'b0);
    // width above the maximum saturates
    send_item(32'd7, 6'd10, 1'b0, 5'd31, 1'b1);
    send_item(32'd7, 6'd8, 1'b1, 5'd17, 1'b0);
    // text longer than the width is not cut
    send_item(32'd123456789, 6'd10, 1'b0, 5'd3, 1'b1);
    send_item(32'h7FFF_FFFF, 6'd10, 1'b1, 5'd16, 1'b0);
    send_item(32'h7FFF_FFFF, 6'd16, 1'b0, 5'd10, 1'b1);
    send_item(32'd255, 6'd16, 1'b1, 5'd8, 1'b0);
    send_item(32'h8000_0000, 6'd36, 1'b0, 5'd16, 1'b0);
    send_item(32'd1, 6'd3, 1'b0, 5'd1, 1'b1);

    // pause the sender until the block has emptied
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: v = $urandom;
        3, 4:    v = $urandom_range(0, 999);
        5:       v = -32'($urandom_range(1, 999));
        6: begin
          case ($urandom_range(0, 3))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h8000_0000;
            default: v = 32'h7FFF_FFFF;
          endcase
        end
        default: v = $urandom >> $urandom_range(0, 31);
      endcase
      // mostly legal radix and width, now and then anything the field holds
      r = ($urandom_range(0, 9) == 0) ? DIGIT_W'($urandom_range(0, 63))
                                      : DIGIT_W'($urandom_range(2, 36));
      w = ($urandom_range(0, 6) == 0) ? WIDTH_W'($urandom_range(0, 31))
                                      : WIDTH_W'($urandom_range(0, 16));
      send_item(v, r, 1'($urandom_range(0, 1)), w, 1'($urandom_range(0, 1)));
      if (i == RANDOM_ITEMS / 2) begin
        wait_drained();
      end
    end

    // drain, then give a stray character time to show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d items (%0d directed) into %0d checked characters.",
             items_sent, DIRECTED_ITEMS, chars_checked);
    $display("Radix 0..63, width 0..31, signed and unsigned values, zero and space pads.");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
